>>> hdl/rnra_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the ring neighbor resource arbiter
package rnra_pkg;

   localparam int MAX_SEATS = 16;
   localparam int SEAT_W    = 4;   // width of the seat field of a request
   localparam int COUNT_W   = 5;   // width of the seat count register
   localparam int MEAL_W    = 16;
   localparam int MASK_W    = 16;
   localparam int CMD_W     = 2;

   localparam int ADDR_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int RING_W = $clog2(MAX_SEATS + 1);
   localparam int IDX_A  = (SEAT_W > COUNT_W) ? SEAT_W : COUNT_W;
   localparam int IDX_W  = (IDX_A > RING_W) ? IDX_A : RING_W;

   localparam logic [COUNT_W-1:0] SEAT_COUNT_RESET = COUNT_W'(5);

   // five-seat window around the addressed seat
   localparam int SLOTS  = 5;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_LEFT  = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_SELF  = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_RIGHT = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(4);

   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

   typedef enum logic [1:0] {
      ST_HUNGRY   = 2'd0,
      ST_THINKING = 2'd1,
      ST_EATING   = 2'd2
   } seat_state_type;

   typedef struct packed {
      seat_state_type      state;
      logic [MEAL_W-1:0]   meals;
   } seat_entry_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
   } store_rd_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      seat_entry_type      data;
   } store_wr_type;

endpackage

>>> hdl/rnra_if.sv
`timescale 1ns / 1ps
// channel interfaces of the ring neighbor resource arbiter

interface rnra_req_if;
   logic                        valid;
   logic                        ready;
   logic [rnra_pkg::CMD_W-1:0]  cmd;
   logic [rnra_pkg::SEAT_W-1:0] seat;

   modport source (output valid, output cmd, output seat, input ready);
   modport sink   (input valid, input cmd, input seat, output ready);
endinterface

interface rnra_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rnra_pkg::MASK_W-1:0] grant_mask;
   logic [rnra_pkg::MEAL_W-1:0] meal_count;

   modport source (output valid, output grant_mask, output meal_count, input ready);
   modport sink   (input valid, input grant_mask, input meal_count, output ready);
endinterface

interface rnra_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rnra_pkg::COUNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/rnra_seat_store.sv
`timescale 1ns / 1ps
// seat state and meal counter memory with per-entry valid bits
module rnra_seat_store (
   input  logic                     clock,
   input  logic                     reset,
   input  rnra_pkg::store_rd_type   rd,
   output rnra_pkg::seat_entry_type rd_data,
   input  rnra_pkg::store_wr_type   wr
);

   rnra_pkg::seat_entry_type mem [rnra_pkg::MAX_SEATS];
   logic [rnra_pkg::MAX_SEATS-1:0] vld_ff;
   rnra_pkg::seat_entry_type rd_mem_ff;
   logic rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_mem_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_vld_ff <= vld_ff[rd.addr];
         end
      end
   end

   // an entry never written since reset reads as thinking with no meals
   always_comb begin
      if (rd_vld_ff) begin
         rd_data = rd_mem_ff;
      end else begin
         rd_data.state = rnra_pkg::ST_THINKING;
         rd_data.meals = '0;
      end
   end

endmodule

>>> hdl/ring_neighbor_resource_arbiter_top.sv
`timescale 1ns / 1ps
// top level of the ring neighbor resource arbiter
//
// usage
//  - req_bus carries one transaction per command: cmd (request, release, query)
//    and the seat it addresses; req_bus.ready is high only while no command is
//    in progress
//  - rsp_bus returns exactly one transaction per command: the mask of seats
//    newly granted eating and the addressed seat's meal counter afterward
//  - csr_bus writes the seat count (clamped to 2..MAX_SEATS); always ready,
//    write it only while no command is pending
//  - a command reads a five-seat window around the addressed seat from a
//    memory with one read and one write port (one read per cycle), updates it
//    in registers, then writes back the left, own and right seats (one write
//    per cycle)
//  - sequence: an in-range command passes the read, drain, calc, write and
//    done states, a seat outside the ring goes straight to done; the next
//    command is taken only once done has loaded the result
//  - reset: all seats thinking with zero meals (valid bits, no clearing pass),
//    seat count 5, no result pending
//  - a stalled rsp_bus holds the result in its output register; one more
//    command may be taken and worked on meanwhile, and it waits at the end
//    until the output register is free
module ring_neighbor_resource_arbiter_top (
   input logic       clock,
   input logic       reset,
   rnra_req_if.sink  req_bus,
   rnra_rsp_if.source rsp_bus,
   rnra_csr_if.sink  csr_bus
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_CALC,
      S_WRITE,
      S_DONE
   } fsm_type;

   fsm_type fsm_ff;

   logic [rnra_pkg::COUNT_W-1:0] seat_count_ff;
   logic [rnra_pkg::CMD_W-1:0]   cmd_ff;
   logic [rnra_pkg::ADDR_W-1:0]  addr_ff [rnra_pkg::SLOTS];
   rnra_pkg::seat_entry_type     slot_ff [rnra_pkg::SLOTS];
   logic [rnra_pkg::SLOT_W-1:0]  slot_idx_ff;
   logic [rnra_pkg::SLOT_W-1:0]  rd_slot_ff;
   logic                         rd_pend_ff;
   logic                         skip_ff;
   logic [rnra_pkg::MASK_W-1:0]  mask_ff;

   logic                         rsp_valid_ff;
   logic [rnra_pkg::MASK_W-1:0]  rsp_mask_ff;
   logic [rnra_pkg::MEAL_W-1:0]  rsp_meal_ff;

   logic [rnra_pkg::IDX_W-1:0]   ring_n;
   logic [rnra_pkg::IDX_W-1:0]   cfg_ext;
   logic [rnra_pkg::IDX_W-1:0]   seat_ext;
   logic [rnra_pkg::IDX_W-1:0]   win [rnra_pkg::SLOTS];
   logic                         in_range;
   logic                         req_take;
   logic                         rsp_load;

   rnra_pkg::seat_entry_type     calc_slot [rnra_pkg::SLOTS];
   logic [rnra_pkg::MASK_W-1:0]  calc_mask;

   rnra_pkg::store_rd_type       store_rd;
   rnra_pkg::store_wr_type       store_wr;
   rnra_pkg::seat_entry_type     store_rd_data;

   function automatic logic [rnra_pkg::IDX_W-1:0] ring_next(
      input logic [rnra_pkg::IDX_W-1:0] x,
      input logic [rnra_pkg::IDX_W-1:0] n
   );
      logic [rnra_pkg::IDX_W-1:0] inc;
      inc = x + rnra_pkg::IDX_W'(1);
      return (inc == n) ? '0 : inc;
   endfunction

   function automatic logic [rnra_pkg::IDX_W-1:0] ring_prev(
      input logic [rnra_pkg::IDX_W-1:0] x,
      input logic [rnra_pkg::IDX_W-1:0] n
   );
      return (x == '0) ? n - rnra_pkg::IDX_W'(1) : x - rnra_pkg::IDX_W'(1);
   endfunction

   // effective ring size, clamped to 2..MAX_SEATS
   always_comb begin
      cfg_ext = rnra_pkg::IDX_W'(seat_count_ff);
      if (cfg_ext < rnra_pkg::IDX_W'(2)) begin
         ring_n = rnra_pkg::IDX_W'(2);
      end else if (cfg_ext > rnra_pkg::IDX_W'(rnra_pkg::MAX_SEATS)) begin
         ring_n = rnra_pkg::IDX_W'(rnra_pkg::MAX_SEATS);
      end else begin
         ring_n = cfg_ext;
      end
   end

   // window of seats two to the left through two to the right
   always_comb begin
      seat_ext = rnra_pkg::IDX_W'(req_bus.seat);
      in_range = seat_ext < ring_n;
      win[rnra_pkg::SLOT_SELF]  = seat_ext;
      win[rnra_pkg::SLOT_LEFT]  = ring_prev(seat_ext, ring_n);
      win[rnra_pkg::SLOT_FIRST] = ring_prev(win[rnra_pkg::SLOT_LEFT], ring_n);
      win[rnra_pkg::SLOT_RIGHT] = ring_next(seat_ext, ring_n);
      win[rnra_pkg::SLOT_LAST]  = ring_next(win[rnra_pkg::SLOT_RIGHT], ring_n);
   end

   assign req_bus.ready = (fsm_ff == S_IDLE);
   assign req_take      = req_bus.valid && (fsm_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_load      = (fsm_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.grant_mask = rsp_mask_ff;
   assign rsp_bus.meal_count = rsp_meal_ff;

   // memory access: reads walk the window, writes go back over left, self, right
   always_comb begin
      store_rd.en   = (fsm_ff == S_READ);
      store_rd.addr = addr_ff[slot_idx_ff];
      store_wr.en   = (fsm_ff == S_WRITE);
      store_wr.addr = addr_ff[slot_idx_ff];
      store_wr.data = slot_ff[slot_idx_ff];
   end

   rnra_seat_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (store_rd),
      .rd_data (store_rd_data),
      .wr      (store_wr)
   );

   // update of the window; slots holding the same seat (small rings) move together
   always_comb begin
      logic                        is_req;
      logic                        is_rel;
      logic                        fire;
      logic [rnra_pkg::SLOT_W-1:0] t;
      logic [rnra_pkg::SLOT_W-1:0] tl;
      logic [rnra_pkg::SLOT_W-1:0] tr;
      logic [rnra_pkg::MEAL_W-1:0] meal_next;

      calc_slot = slot_ff;
      calc_mask = '0;
      is_req    = 1'b0;
      is_rel    = 1'b0;
      case (cmd_ff)
         rnra_pkg::CMD_REQUEST: is_req = 1'b1;
         rnra_pkg::CMD_RELEASE: is_rel = 1'b1;
         rnra_pkg::CMD_QUERY: begin
         end
         default: begin
            // unused code reads like a query
         end
      endcase

      for (int k = 0; k < rnra_pkg::SLOTS; k++) begin
         if (addr_ff[k] == addr_ff[rnra_pkg::SLOT_SELF]) begin
            if (is_req) begin
               calc_slot[k].state = rnra_pkg::ST_HUNGRY;
            end else if (is_rel) begin
               calc_slot[k].state = rnra_pkg::ST_THINKING;
            end
         end
      end

      // request tests self; release tests left, then right
      for (int g = 0; g < 2; g++) begin
         t    = is_rel ? ((g == 0) ? rnra_pkg::SLOT_LEFT : rnra_pkg::SLOT_RIGHT)
                       : rnra_pkg::SLOT_SELF;
         tl   = t - rnra_pkg::SLOT_W'(1);
         tr   = t + rnra_pkg::SLOT_W'(1);
         fire = (is_rel || (is_req && (g == 0))) &&
                (calc_slot[t].state == rnra_pkg::ST_HUNGRY) &&
                (calc_slot[tl].state != rnra_pkg::ST_EATING) &&
                (calc_slot[tr].state != rnra_pkg::ST_EATING);
         meal_next = (calc_slot[t].meals == '1) ? calc_slot[t].meals
                                                : calc_slot[t].meals + rnra_pkg::MEAL_W'(1);
         if (fire) begin
            for (int k = 0; k < rnra_pkg::SLOTS; k++) begin
               if (addr_ff[k] == addr_ff[t]) begin
                  calc_slot[k].state = rnra_pkg::ST_EATING;
                  calc_slot[k].meals = meal_next;
               end
            end
            if (rnra_pkg::IDX_W'(addr_ff[t]) < rnra_pkg::IDX_W'(rnra_pkg::MASK_W)) begin
               calc_mask = calc_mask | (rnra_pkg::MASK_W'(1) << addr_ff[t]);
            end
         end
      end
   end

   // sequencer with the registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         seat_count_ff <= rnra_pkg::SEAT_COUNT_RESET;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            seat_count_ff <= csr_bus.data;
         end

         // read data arrives in the cycle after its address
         rd_pend_ff <= (fsm_ff == S_READ);
         rd_slot_ff <= slot_idx_ff;
         if (rd_pend_ff) begin
            slot_ff[rd_slot_ff] <= store_rd_data;
         end

         // output register: loaded when free or being taken, else emptied on take
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (fsm_ff)
            S_IDLE: begin
               if (req_take) begin
                  cmd_ff      <= req_bus.cmd;
                  skip_ff     <= !in_range;
                  slot_idx_ff <= rnra_pkg::SLOT_FIRST;
                  for (int k = 0; k < rnra_pkg::SLOTS; k++) begin
                     addr_ff[k] <= win[k][rnra_pkg::ADDR_W-1:0];
                  end
                  fsm_ff <= in_range ? S_READ : S_DONE;
               end
            end
            S_READ: begin
               if (slot_idx_ff == rnra_pkg::SLOT_LAST) begin
                  fsm_ff <= S_DRAIN;
               end else begin
                  slot_idx_ff <= slot_idx_ff + rnra_pkg::SLOT_W'(1);
               end
            end
            S_DRAIN: begin
               fsm_ff <= S_CALC;
            end
            S_CALC: begin
               slot_ff     <= calc_slot;
               mask_ff     <= calc_mask;
               slot_idx_ff <= rnra_pkg::SLOT_LEFT;
               fsm_ff      <= S_WRITE;
            end
            S_WRITE: begin
               if (slot_idx_ff == rnra_pkg::SLOT_RIGHT) begin
                  fsm_ff <= S_DONE;
               end else begin
                  slot_idx_ff <= slot_idx_ff + rnra_pkg::SLOT_W'(1);
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_mask_ff  <= skip_ff ? '0 : mask_ff;
                  rsp_meal_ff  <= skip_ff ? '0 : slot_ff[rnra_pkg::SLOT_SELF].meals;
                  fsm_ff       <= S_IDLE;
               end
            end
            default: begin
               fsm_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // reads and write-back never overlap, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(store_rd.en && store_wr.en))
      else $error("seat store read and write in the same cycle");

   // one command grants at most two seats
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ($countones(rsp_bus.grant_mask) <= 2))
      else $error("more than two grants in one result");

   // grants stay inside the ring
   a_grant_in_ring: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.grant_mask >> ring_n) == '0))
      else $error("grant to a seat outside the ring");

   // a seat outside the ring yields an all-zero result
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && skip_ff) |=> (rsp_bus.grant_mask == '0 && rsp_bus.meal_count == '0))
      else $error("nonzero result for a seat outside the ring");
`endif

endmodule
